// ===== rtl/slsrd_pkg.sv =====
// Shared types, codes and constants for the S/PDIF link supervisor with rate detection.
// Holds the link state, action and rate codes and the rate threshold table.
// Depends on nothing.
package slsrd_pkg;

  // Widths of the transaction fields and the configuration register.
  localparam int unsigned ActionW   = 2;
  localparam int unsigned ErrW      = 3;
  localparam int unsigned WidthW    = 15;
  localparam int unsigned StateW    = 3;
  localparam int unsigned RateW     = 3;
  localparam int unsigned ClkFreqW  = 28;

  // Estimate arithmetic widths: five times the clock, threshold times width.
  localparam int unsigned NumW      = ClkFreqW + 3;
  localparam int unsigned ThrW      = 18;
  localparam int unsigned ProdW     = WidthW + ThrW;
  localparam int unsigned DenShift  = 6;
  localparam int unsigned CmpW      = ProdW + DenShift;

  // Rate thresholds walked from the fastest class down.
  localparam int unsigned NumThr    = 5;
  localparam int unsigned ThrIdxW   = 3;

  // Action codes.
  localparam logic [ActionW-1:0] ACT_TICK  = 2'd0;
  localparam logic [ActionW-1:0] ACT_START = 2'd1;
  localparam logic [ActionW-1:0] ACT_STOP  = 2'd2;

  // Link state codes.
  localparam logic [StateW-1:0] LINK_STOP     = 3'd0;
  localparam logic [StateW-1:0] LINK_INACTIVE = 3'd1;
  localparam logic [StateW-1:0] LINK_INIT     = 3'd2;
  localparam logic [StateW-1:0] LINK_SYNCHRO  = 3'd3;
  localparam logic [StateW-1:0] LINK_RUN      = 3'd4;

  // Rate codes.
  localparam logic [RateW-1:0] RATE_UNKNOWN = 3'd0;
  localparam logic [RateW-1:0] RATE_32K     = 3'd1;
  localparam logic [RateW-1:0] RATE_44K1    = 3'd2;
  localparam logic [RateW-1:0] RATE_48K     = 3'd3;
  localparam logic [RateW-1:0] RATE_96K     = 3'd4;
  localparam logic [RateW-1:0] RATE_192K    = 3'd5;

  // The estimate exceeds a threshold T exactly when num >= (T + 1) * den,
  // so the table holds each threshold plus one.
  function automatic logic [ThrW-1:0] rate_thr(input logic [ThrIdxW-1:0] idx);
    logic [ThrW-1:0] thr;
    case (idx)
      3'd0:    thr = 18'd190001;
      3'd1:    thr = 18'd90001;
      3'd2:    thr = 18'd46001;
      3'd3:    thr = 18'd40001;
      default: thr = 18'd3001;
    endcase
    return thr;
  endfunction

  // Rate code that belongs to each threshold step.
  function automatic logic [RateW-1:0] rate_of(input logic [ThrIdxW-1:0] idx);
    logic [RateW-1:0] code;
    case (idx)
      3'd0:    code = RATE_192K;
      3'd1:    code = RATE_96K;
      3'd2:    code = RATE_48K;
      3'd3:    code = RATE_44K1;
      default: code = RATE_32K;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/spdif_link_supervisor_rate_detect.sv =====
// Top level of the S/PDIF link supervisor with sample-rate detection.
// Uses slsrd_pkg for codes, widths and the rate threshold table.
// Contains the link state machine, the estimate sequencer and the output register.
//
//   Channel   Handshake                    Payload
//   -------   --------------------------   --------------------------------------------
//   config    cfg_we_i                     cfg_wdata_i (clock_freq_hz)
//   input     in_valid_i / in_stall_o      action_i, sync_detected_i, error_flags_i,
//                                          width_count_i
//   output    out_valid_o / out_stall_i    link_state_o, abort_idle_o, sync_request_o,
//                                          start_flow_o, rate_code_o
//
// A transaction without a rate estimate goes from acceptance straight to the done state.
// A rate estimate adds a multiply step and a compare step per threshold tried with the one
// shared multiplier and comparator, and stops at the first threshold passed or the last one.
// The input is stalled from acceptance until the result is loaded into the output register.
// A result waits in the output register while the next transaction is accepted; a full
// output register holds the next result back and keeps the input stalled.
// Reset puts the link in inactive with an unknown rate and a zero clock frequency.
module spdif_link_supervisor_rate_detect (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [slsrd_pkg::ClkFreqW-1:0]     cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [slsrd_pkg::ActionW-1:0]      action_i,
  input  logic                               sync_detected_i,
  input  logic [slsrd_pkg::ErrW-1:0]         error_flags_i,
  input  logic [slsrd_pkg::WidthW-1:0]       width_count_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [slsrd_pkg::StateW-1:0]       link_state_o,
  output logic                               abort_idle_o,
  output logic                               sync_request_o,
  output logic                               start_flow_o,
  output logic [slsrd_pkg::RateW-1:0]        rate_code_o
);

  // Sequencer state codes.
  localparam logic [1:0] SEQ_IDLE = 2'd0;
  localparam logic [1:0] SEQ_MUL  = 2'd1;
  localparam logic [1:0] SEQ_CMP  = 2'd2;
  localparam logic [1:0] SEQ_DONE = 2'd3;

  logic [1:0]                       seq_q, seq_d;
  logic [slsrd_pkg::ClkFreqW-1:0]   clk_freq_q;
  logic [slsrd_pkg::StateW-1:0]     link_q, link_d;
  logic [slsrd_pkg::RateW-1:0]      rate_q;
  logic [slsrd_pkg::WidthW-1:0]     width_q;
  logic [slsrd_pkg::ThrIdxW-1:0]    idx_q;
  logic [slsrd_pkg::ProdW-1:0]      prod_q;
  logic                             abort_q, sync_req_q, start_q;
  logic                             abort_d, sync_req_d, start_d;
  logic                             est_go;
  logic                             in_acc;
  logic                             out_free;
  logic                             out_load;
  logic [slsrd_pkg::NumW-1:0]       num;
  logic [slsrd_pkg::ProdW-1:0]      mul;
  logic                             above;
  logic                             last_thr;

  logic                             out_valid_q;
  logic [slsrd_pkg::StateW-1:0]     out_link_q;
  logic                             out_abort_q, out_sync_q, out_start_q;
  logic [slsrd_pkg::RateW-1:0]      out_rate_q;

  assign in_stall_o = (seq_q != SEQ_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (seq_q == SEQ_DONE) && out_free;

  // Link state machine: the next state and the pulses for the accepted transaction.
  always_comb begin
    link_d     = link_q;
    abort_d    = 1'b0;
    sync_req_d = 1'b0;
    start_d    = 1'b0;
    est_go     = 1'b0;
    unique case (action_i)
      slsrd_pkg::ACT_START: begin
        link_d = slsrd_pkg::LINK_INIT;
      end
      slsrd_pkg::ACT_STOP: begin
        link_d = slsrd_pkg::LINK_STOP;
      end
      slsrd_pkg::ACT_TICK: begin
        unique case (link_q)
          slsrd_pkg::LINK_STOP: begin
            abort_d = 1'b1;
            link_d  = slsrd_pkg::LINK_INACTIVE;
          end
          slsrd_pkg::LINK_INIT: begin
            abort_d    = 1'b1;
            sync_req_d = 1'b1;
            link_d     = slsrd_pkg::LINK_SYNCHRO;
          end
          slsrd_pkg::LINK_SYNCHRO: begin
            if (sync_detected_i) begin
              start_d = 1'b1;
              est_go  = (width_count_i != '0);
              link_d  = slsrd_pkg::LINK_RUN;
            end else begin
              link_d = slsrd_pkg::LINK_INIT;
            end
          end
          slsrd_pkg::LINK_RUN: begin
            if (error_flags_i != '0) begin
              link_d = slsrd_pkg::LINK_INIT;
            end
          end
          default: begin
            link_d = slsrd_pkg::LINK_INACTIVE;
          end
        endcase
      end
      default: begin
        // The unused action code leaves everything as it is.
        link_d = link_q;
      end
    endcase
  end

  // Shared estimate unit: the width times one threshold, then a compare against five
  // times the clock. The den factor of 64 is a shift of the registered product.
  assign num      = (slsrd_pkg::NumW'(clk_freq_q) << 2) + slsrd_pkg::NumW'(clk_freq_q);
  assign mul      = slsrd_pkg::ProdW'(width_q) * slsrd_pkg::ProdW'(slsrd_pkg::rate_thr(idx_q));
  assign above    = ({prod_q, slsrd_pkg::DenShift'(0)} <= slsrd_pkg::CmpW'(num));
  assign last_thr = (idx_q == slsrd_pkg::ThrIdxW'(slsrd_pkg::NumThr - 1));

  // Estimate sequencer.
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_IDLE: begin
        if (in_acc) begin
          seq_d = est_go ? SEQ_MUL : SEQ_DONE;
        end
      end
      SEQ_MUL: begin
        seq_d = SEQ_CMP;
      end
      SEQ_CMP: begin
        seq_d = (above || last_thr) ? SEQ_DONE : SEQ_MUL;
      end
      SEQ_DONE: begin
        if (out_free) begin
          seq_d = SEQ_IDLE;
        end
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
  end

  // Control registers: sequencer, link state, rate, the clock frequency register and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      link_q      <= slsrd_pkg::LINK_INACTIVE;
      rate_q      <= slsrd_pkg::RATE_UNKNOWN;
      clk_freq_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seq_q <= seq_d;
      if (cfg_we_i) begin
        clk_freq_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        link_q <= link_d;
      end
      if ((seq_q == SEQ_CMP) && above) begin
        rate_q <= slsrd_pkg::rate_of(idx_q);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the transaction in flight.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      abort_q    <= abort_d;
      sync_req_q <= sync_req_d;
      start_q    <= start_d;
      width_q    <= width_count_i;
      idx_q      <= '0;
    end else if ((seq_q == SEQ_CMP) && !above && !last_thr) begin
      idx_q <= idx_q + 1'b1;
    end
    if (seq_q == SEQ_MUL) begin
      prod_q <= mul;
    end
  end

  // Output register holds a finished result until it is taken.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_link_q  <= link_q;
      out_abort_q <= abort_q;
      out_sync_q  <= sync_req_q;
      out_start_q <= start_q;
      out_rate_q  <= rate_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign link_state_o   = out_link_q;
  assign abort_idle_o   = out_abort_q;
  assign sync_request_o = out_sync_q;
  assign start_flow_o   = out_start_q;
  assign rate_code_o    = out_rate_q;

`ifndef NO_ASSERTIONS
  // A start pulse only comes with the move into run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && start_flow_o |-> link_state_o == slsrd_pkg::LINK_RUN)
    else $error("start pulse outside run");

  // A sync request is always paired with an abort and the move into synchro.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sync_request_o |-> abort_idle_o &&
      link_state_o == slsrd_pkg::LINK_SYNCHRO)
    else $error("sync request without abort or synchro");

  // The rate only changes while an estimate step is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(seq_q) != SEQ_CMP |-> $stable(rate_q))
    else $error("rate changed outside the estimate");

  // An accepted transaction always blocks the input on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after acceptance");
`endif

endmodule

// ===== sim/tb_spdif_link_supervisor_rate_detect.sv =====
// Self-checking testbench for spdif_link_supervisor_rate_detect.
// Drives directed and random link transactions over several reference clock settings.
// Depends on slsrd_pkg and the block's RTL only.
module tb_spdif_link_supervisor_rate_detect;

  // Action code 3 has no meaning; the block must ignore it.
  localparam logic [slsrd_pkg::ActionW-1:0] ACT_UNUSED = 2'd3;

  localparam int unsigned ClkHalf     = 10;
  localparam int unsigned ResetCycles = 11;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned PhaseItems  = 105;
  localparam int unsigned NumPhases   = 5;

  // Estimate boundaries between the rate classes.
  localparam longint unsigned Est192k = 190000;
  localparam longint unsigned Est96k  = 90000;
  localparam longint unsigned Est48k  = 46000;
  localparam longint unsigned Est44k1 = 40000;
  localparam longint unsigned Est32k  = 3000;

  localparam logic [slsrd_pkg::ClkFreqW-1:0] ClkMax = 28'd250000000;

  typedef struct packed {
    logic [slsrd_pkg::StateW-1:0] link_state;
    logic                         abort_idle;
    logic                         sync_request;
    logic                         start_flow;
    logic [slsrd_pkg::RateW-1:0]  rate_code;
  } link_result_t;

  // Link supervisor predictor and the queue of results it still owes.
  class link_scoreboard;
    logic [slsrd_pkg::ClkFreqW-1:0] clk_hz;
    logic [slsrd_pkg::StateW-1:0]   link;
    logic [slsrd_pkg::RateW-1:0]    rate;
    link_result_t                   expected_q[$];
    int unsigned                    errors;
    int unsigned                    checked;
    int unsigned                    locks[6];

    function new();
      clk_hz  = '0;
      link    = slsrd_pkg::LINK_INACTIVE;
      rate    = slsrd_pkg::RATE_UNKNOWN;
      errors  = 0;
      checked = 0;
      foreach (locks[i]) locks[i] = 0;
    endfunction

    function void set_clock(logic [slsrd_pkg::ClkFreqW-1:0] hz);
      clk_hz = hz;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // A zero width or a low estimate leaves the rate as it was.
    function void classify_rate(logic [slsrd_pkg::WidthW-1:0] w);
      longint unsigned num, den, est;
      if (w == '0) return;
      num = 64'(clk_hz) * 64'd5;
      den = 64'(w) * 64'd64;
      est = num / den;
      if (est > Est192k) rate = slsrd_pkg::RATE_192K;
      else if (est > Est96k) rate = slsrd_pkg::RATE_96K;
      else if (est > Est48k) rate = slsrd_pkg::RATE_48K;
      else if (est > Est44k1) rate = slsrd_pkg::RATE_44K1;
      else if (est > Est32k) rate = slsrd_pkg::RATE_32K;
      locks[rate]++;
    endfunction

    // Advance the link by one accepted input transaction.
    function void note_input(logic [slsrd_pkg::ActionW-1:0] act, logic sync,
                             logic [slsrd_pkg::ErrW-1:0] errs,
                             logic [slsrd_pkg::WidthW-1:0] w);
      link_result_t r;
      r = '0;
      case (act)
        slsrd_pkg::ACT_START: link = slsrd_pkg::LINK_INIT;
        slsrd_pkg::ACT_STOP:  link = slsrd_pkg::LINK_STOP;
        slsrd_pkg::ACT_TICK: begin
          case (link)
            slsrd_pkg::LINK_STOP: begin
              r.abort_idle = 1'b1;
              link = slsrd_pkg::LINK_INACTIVE;
            end
            slsrd_pkg::LINK_INIT: begin
              r.abort_idle   = 1'b1;
              r.sync_request = 1'b1;
              link = slsrd_pkg::LINK_SYNCHRO;
            end
            slsrd_pkg::LINK_SYNCHRO: begin
              if (sync) begin
                r.start_flow = 1'b1;
                classify_rate(w);
                link = slsrd_pkg::LINK_RUN;
              end else begin
                link = slsrd_pkg::LINK_INIT;
              end
            end
            slsrd_pkg::LINK_RUN: begin
              if (errs != '0) link = slsrd_pkg::LINK_INIT;
            end
            default: link = slsrd_pkg::LINK_INACTIVE;
          endcase
        end
        default: ;
      endcase
      r.link_state = link;
      r.rate_code  = rate;
      expected_q.push_back(r);
    endfunction

    function void check_field(string field, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
      end
    endfunction

    // Compare one result transaction with the oldest expectation.
    function void check_result(link_result_t got);
      link_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, actual %p", $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      check_field("link_state", 8'(want.link_state), 8'(got.link_state));
      check_field("abort_idle", 8'(want.abort_idle), 8'(got.abort_idle));
      check_field("sync_request", 8'(want.sync_request), 8'(got.sync_request));
      check_field("start_flow", 8'(want.start_flow), 8'(got.start_flow));
      check_field("rate_code", 8'(want.rate_code), 8'(got.rate_code));
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [slsrd_pkg::ClkFreqW-1:0]  cfg_wdata_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic [slsrd_pkg::ActionW-1:0]   action_i;
  logic                            sync_detected_i;
  logic [slsrd_pkg::ErrW-1:0]      error_flags_i;
  logic [slsrd_pkg::WidthW-1:0]    width_count_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [slsrd_pkg::StateW-1:0]    link_state_o;
  logic                            abort_idle_o;
  logic                            sync_request_o;
  logic                            start_flow_o;
  logic [slsrd_pkg::RateW-1:0]     rate_code_o;

  link_scoreboard sb;
  link_result_t   seen;
  int unsigned    idle_cycles = 0;
  int unsigned    stall_cycles = 0;
  int unsigned    items_sent = 0;
  int unsigned    burst_left = 0;
  int unsigned    settings = 0;

  spdif_link_supervisor_rate_detect dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .sync_detected_i (sync_detected_i),
    .error_flags_i   (error_flags_i),
    .width_count_i   (width_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .link_state_o    (link_state_o),
    .abort_idle_o    (abort_idle_o),
    .sync_request_o  (sync_request_o),
    .start_flow_o    (start_flow_o),
    .rate_code_o     (rate_code_o)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Check each accepted result and track cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      seen.link_state   = link_state_o;
      seen.abort_idle   = abort_idle_o;
      seen.sync_request = sync_request_o;
      seen.start_flow   = start_flow_o;
      seen.rate_code    = rate_code_o;
      sb.check_result(seen);
    end
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // The run ends here if the block stops moving transactions.
  initial begin : watchdog
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
    $display("tb: failure");
    $finish;
  end

  // Receiver stall pattern: free, sparse random, long holds, or toggling.
  initial begin : rx_stall
    int unsigned mode, span, hold;
    out_stall_i = 1'b0;
    mode = 0;
    span = 0;
    hold = 0;
    forever begin
      @(negedge clk_i);
      if (span == 0) begin
        mode = $urandom_range(3);
        span = $urandom_range(80, 20);
      end
      span--;
      case (mode)
        0: out_stall_i = 1'b0;
        1: out_stall_i = ($urandom_range(3) == 0);
        2: begin
          if (hold == 0) begin
            hold = $urandom_range(8, 1);
            out_stall_i = ~out_stall_i;
          end
          hold--;
        end
        default: out_stall_i = ~out_stall_i;
      endcase
      if (out_stall_i) stall_cycles++;
    end
  end

  // Widths that land in each rate class for the current clock, plus raw noise.
  function automatic logic [slsrd_pkg::WidthW-1:0] pick_width(
      logic [slsrd_pkg::ClkFreqW-1:0] hz);
    longint unsigned w, target;
    case ($urandom_range(7))
      0: return slsrd_pkg::WidthW'($urandom);
      1: return '0;
      2: return slsrd_pkg::WidthW'($urandom_range(64, 1));
      default: begin
        case ($urandom_range(4))
          0: target = 32000;
          1: target = 44100;
          2: target = 48000;
          3: target = 96000;
          default: target = 192000;
        endcase
        w = (64'(hz) * 64'd5) / (64'd64 * target) + $urandom_range(2);
        if (w > 0) w = w - 1;
        if (w > 32767) w = 32767;
        return w[slsrd_pkg::WidthW-1:0];
      end
    endcase
  endfunction

  // Present one input transaction, wait for it to be taken, then maybe pause.
  task automatic push_item(input logic [slsrd_pkg::ActionW-1:0] act, input logic sync,
                           input logic [slsrd_pkg::ErrW-1:0] errs,
                           input logic [slsrd_pkg::WidthW-1:0] w);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i      = 1'b1;
    action_i        = act;
    sync_detected_i = sync;
    error_flags_i   = errs;
    width_count_i   = w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_input(act, sync, errs, w);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(15);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 1);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // Tick with don't-care fields randomized.
  task automatic tick_noise(input logic [slsrd_pkg::ErrW-1:0] errs);
    push_item(slsrd_pkg::ACT_TICK, 1'($urandom), errs, slsrd_pkg::WidthW'($urandom));
  endtask

  // Start command, init tick, then the synchro tick that carries the width.
  task automatic lock_at(input logic [slsrd_pkg::WidthW-1:0] w, input logic sync);
    push_item(slsrd_pkg::ACT_START, 1'($urandom), slsrd_pkg::ErrW'($urandom),
              slsrd_pkg::WidthW'($urandom));
    tick_noise(slsrd_pkg::ErrW'($urandom));
    push_item(slsrd_pkg::ACT_TICK, sync, slsrd_pkg::ErrW'($urandom), w);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Clock register writes happen only with the block idle.
  task automatic write_clock(input logic [slsrd_pkg::ClkFreqW-1:0] hz);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = hz;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_clock(hz);
    settings++;
  endtask

  // Mostly full lock sequences with random content, some stops and raw noise.
  task automatic run_phase(input int unsigned count);
    int unsigned first, sel;
    first = items_sent;
    while (items_sent - first < count) begin
      sel = $urandom_range(99);
      if (sel < 70) begin
        lock_at(pick_width(sb.clk_hz), $urandom_range(9) != 0);
        repeat ($urandom_range(6)) tick_noise('0);
        if ($urandom_range(1)) tick_noise(slsrd_pkg::ErrW'($urandom_range(7, 1)));
      end else if (sel < 85) begin
        push_item(slsrd_pkg::ACT_STOP, 1'($urandom), slsrd_pkg::ErrW'($urandom),
                  slsrd_pkg::WidthW'($urandom));
        repeat ($urandom_range(2, 1)) tick_noise(slsrd_pkg::ErrW'($urandom));
      end else begin
        push_item(slsrd_pkg::ActionW'($urandom), 1'($urandom), slsrd_pkg::ErrW'($urandom),
                  slsrd_pkg::WidthW'($urandom));
      end
    end
  endtask

  initial begin
    logic [slsrd_pkg::ClkFreqW-1:0] phase_clk;
    sb              = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_valid_i      = 1'b0;
    action_i        = slsrd_pkg::ACT_TICK;
    sync_detected_i = 1'b0;
    error_flags_i   = '0;
    width_count_i   = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // With the reset clock of zero, every estimate is too low to change the rate.
    tick_noise('0);
    push_item(ACT_UNUSED, 1'b1, '1, '1);
    lock_at(slsrd_pkg::WidthW'(100), 1'b1);

    write_clock(ClkMax);
    // Errors in run, synchro without sync, and a zero width.
    push_item(slsrd_pkg::ACT_TICK, 1'b0, 3'b001, '0);
    tick_noise('0);
    push_item(slsrd_pkg::ACT_TICK, 1'b0, '0, slsrd_pkg::WidthW'(1));
    tick_noise('0);
    push_item(slsrd_pkg::ACT_TICK, 1'b1, '0, '0);
    push_item(slsrd_pkg::ACT_TICK, 1'b1, 3'b010, '0);
    tick_noise('0);
    push_item(slsrd_pkg::ACT_TICK, 1'b1, '0, slsrd_pkg::WidthW'(1));
    push_item(slsrd_pkg::ACT_TICK, 1'b0, 3'b100, '0);
    tick_noise('0);
    push_item(slsrd_pkg::ACT_TICK, 1'b1, '0, slsrd_pkg::WidthW'(200));
    // Remaining rate classes, then a width too long for any class.
    lock_at(slsrd_pkg::WidthW'(400), 1'b1);
    lock_at(slsrd_pkg::WidthW'(450), 1'b1);
    lock_at(slsrd_pkg::WidthW'(1000), 1'b1);
    lock_at('1, 1'b1);
    push_item(slsrd_pkg::ACT_STOP, 1'b1, '1, '1);
    tick_noise('1);

    // Random phases over a spread of reference clocks, extremes included.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: phase_clk = 28'd24576000;
        1: phase_clk = '0;
        2: phase_clk = ClkMax;
        3: phase_clk = 28'd49152000;
        default: phase_clk = slsrd_pkg::ClkFreqW'($urandom_range(ClkMax));
      endcase
      write_clock(phase_clk);
      run_phase(PhaseItems);
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);

    $display("tb: %0d transactions checked under %0d clock settings, %0d receiver stall cycles",
             sb.checked, settings, stall_cycles);
    $display("tb: rate locks unknown %0d, 32k %0d, 44.1k %0d, 48k %0d, 96k %0d, 192k %0d",
             sb.locks[0], sb.locks[1], sb.locks[2], sb.locks[3], sb.locks[4], sb.locks[5]);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
